>>> design/xed_pkg.sv
// Shared types, constants and entity tables for the XML entity decoder.
// No dependencies.
package xed_pkg;

    localparam int PENDING_DEPTH = 16;
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W = $clog2(PENDING_DEPTH);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int NAME_COUNT = 5;
    localparam int CODE_W = 21;

    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_NAME   = 2'd1;
    localparam logic [1:0] MODE_DIGITS = 2'd2;

    localparam logic [CODE_W-1:0] MAX_CODE   = 21'h10FFFF;
    localparam logic [CODE_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CODE_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CODE_W-1:0] REPL_CHAR  = 21'h00FFFD;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } out_t;

    // queue word: a plain byte, or a code point still to be UTF-8 encoded
    typedef struct packed {
        logic              is_code;
        logic [CODE_W-1:0] value;
        logic              last;
    } cmd_t;

    // entity names, byte p at [8p +: 8], without the leading '&'
    function automatic logic [39:0] ent_name(input logic [2:0] i);
        logic [39:0] s;
        unique case (i)
            3'd0:    s = 40'h00_00_3B_74_6C;   // lt;
            3'd1:    s = 40'h00_00_3B_74_67;   // gt;
            3'd2:    s = 40'h00_3B_70_6D_61;   // amp;
            3'd3:    s = 40'h3B_74_6F_75_71;   // quot;
            3'd4:    s = 40'h3B_73_6F_70_61;   // apos;
            default: s = 40'h0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] ent_len(input logic [2:0] i);
        logic [2:0] n;
        unique case (i)
            3'd0, 3'd1: n = 3'd3;
            3'd2:       n = 3'd4;
            3'd3, 3'd4: n = 3'd5;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] ent_glyph(input logic [2:0] i);
        logic [7:0] g;
        unique case (i)
            3'd0:    g = 8'h3C;
            3'd1:    g = 8'h3E;
            3'd2:    g = 8'h26;
            3'd3:    g = 8'h22;
            3'd4:    g = 8'h27;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

>>> design/xed_front.sv
// Front end: accepts text bytes, tracks entity candidates and the pending buffer,
// and issues byte/code words to the queue. Flushes pending bytes word by word.
// Depends on xed_pkg.
module xed_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  xed_pkg::in_t item,
    input  logic         q_full,
    output logic         push,
    output xed_pkg::cmd_t push_cmd
);
    import xed_pkg::*;

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic              state_reg, state_next;
    logic [7:0]        pend_reg [PENDING_DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        mode_reg, mode_next;
    logic [CODE_W-1:0] value_reg, value_next;
    logic              tl_reg, tl_next;
    logic [NAME_COUNT-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  seq_last_reg, seq_last_next;
    logic [CNT_W-1:0]  flush_len_reg, flush_len_next;
    logic [7:0]        tail_byte_reg, tail_byte_next;
    logic              end_reg, end_next;
    logic              tail_start_reg, tail_start_next;

    logic              accept;
    logic [7:0]        c;
    logic              eot;
    logic              hold_ok;
    logic              is_digit;
    logic [2:0]        pos;
    logic [NAME_COUNT-1:0] match_mask;
    logic              hit;
    logic [7:0]        hit_glyph;
    logic [24:0]       dsum;
    logic              do_hold, do_mis, do_clear, tail_emit;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [7:0]        wr_data;

    assign item_stall = !((state_reg == ST_RUN) && !q_full);
    assign accept     = item_valid && !item_stall;
    assign c          = item.in_byte;
    assign eot        = item.end_of_text;
    assign hold_ok    = count_reg < CNT_W'(PENDING_DEPTH);
    assign is_digit   = (c >= CH_0) && (c <= CH_9);
    assign pos        = 3'(count_reg - CNT_W'(1));
    assign dsum       = (25'(value_reg) << 3) + (25'(value_reg) << 1) + 25'(c[3:0]);

    // all five names compared in parallel at the current position
    always_comb
    begin
        logic [39:0] nm;
        logic [2:0]  ln;
        match_mask = '0;
        hit        = 1'b0;
        hit_glyph  = 8'h00;
        for (int i = 0; i < NAME_COUNT; i++)
        begin
            nm = ent_name(3'(i));
            ln = ent_len(3'(i));
            if (mask_reg[i] && (pos < ln) && (nm[8*pos +: 8] == c))
            begin
                if (pos + 3'd1 == ln)
                begin
                    hit       = 1'b1;
                    hit_glyph = ent_glyph(3'(i));
                end
                else
                begin
                    match_mask[i] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        mode_next       = mode_reg;
        value_next      = value_reg;
        tl_next         = tl_reg;
        mask_next       = mask_reg;
        idx_next        = idx_reg;
        seq_last_next   = seq_last_reg;
        flush_len_next  = flush_len_reg;
        tail_byte_next  = tail_byte_reg;
        end_next        = end_reg;
        tail_start_next = tail_start_reg;
        push            = 1'b0;
        push_cmd        = '0;
        wr_en           = 1'b0;
        wr_idx          = count_reg[IDX_W-1:0];
        wr_data         = c;
        do_hold         = 1'b0;
        do_mis          = 1'b0;
        do_clear        = 1'b0;
        tail_emit       = 1'b0;

        if (state_reg == ST_RUN)
        begin
            if (accept)
            begin
                unique case (mode_reg)
                    MODE_NAME:
                    begin
                        if ((count_reg == CNT_W'(1)) && (c == CH_HASH))
                        begin
                            do_hold   = 1'b1;
                            mode_next = MODE_DIGITS;
                        end
                        else if (hit)
                        begin
                            push           = 1'b1;
                            push_cmd.value = CODE_W'(hit_glyph);
                            push_cmd.last  = eot;
                            do_clear       = 1'b1;
                        end
                        else if (match_mask == '0)
                        begin
                            do_mis = 1'b1;
                        end
                        else
                        begin
                            do_hold   = 1'b1;
                            mask_next = match_mask;
                        end
                    end
                    MODE_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            do_hold = 1'b1;
                            if (!tl_reg)
                            begin
                                if (dsum > 25'(MAX_CODE))
                                begin
                                    tl_next    = 1'b1;
                                    value_next = MAX_CODE;
                                end
                                else
                                begin
                                    value_next = dsum[CODE_W-1:0];
                                end
                            end
                        end
                        else if ((c == CH_SEMI) && (count_reg > CNT_W'(2)) && !tl_reg
                                 && (value_reg != '0))
                        begin
                            push             = 1'b1;
                            push_cmd.is_code = 1'b1;
                            push_cmd.value   = value_reg;
                            push_cmd.last    = eot;
                            do_clear         = 1'b1;
                        end
                        else
                        begin
                            do_mis = 1'b1;
                        end
                    end
                    default:
                    begin
                        if ((c == CH_AMP) && !eot)
                        begin
                            wr_en      = 1'b1;
                            wr_idx     = '0;
                            count_next = CNT_W'(1);
                            mode_next  = MODE_NAME;
                            value_next = '0;
                            tl_next    = 1'b0;
                            mask_next  = '1;
                        end
                        else
                        begin
                            push           = 1'b1;
                            push_cmd.value = CODE_W'(c);
                            push_cmd.last  = eot;
                        end
                    end
                endcase

                // full buffer turns the candidate into plain text
                if (do_hold && !hold_ok)
                begin
                    do_hold = 1'b0;
                    do_mis  = 1'b1;
                end

                if (do_hold)
                begin
                    wr_en = 1'b1;
                    if (eot)
                    begin
                        flush_len_next  = count_reg + CNT_W'(1);
                        seq_last_next   = count_reg;
                        tail_start_next = 1'b0;
                        end_next        = 1'b1;
                        idx_next        = '0;
                        state_next      = ST_FLUSH;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end

                if (do_mis)
                begin
                    tail_emit       = (c != CH_AMP) || eot;
                    flush_len_next  = count_reg;
                    seq_last_next   = tail_emit ? count_reg : (count_reg - CNT_W'(1));
                    tail_byte_next  = c;
                    end_next        = eot;
                    tail_start_next = (c == CH_AMP) && !eot;
                    idx_next        = '0;
                    state_next      = ST_FLUSH;
                end

                if (do_clear)
                begin
                    count_next = '0;
                    mode_next  = MODE_PLAIN;
                    value_next = '0;
                    tl_next    = 1'b0;
                    mask_next  = '1;
                end
            end
        end
        else
        begin
            if (!q_full)
            begin
                push           = 1'b1;
                push_cmd.value = (idx_reg < flush_len_reg)
                               ? CODE_W'(pend_reg[idx_reg[IDX_W-1:0]])
                               : CODE_W'(tail_byte_reg);
                push_cmd.last  = (idx_reg == seq_last_reg) && end_reg;
                if (idx_reg == seq_last_reg)
                begin
                    state_next = ST_RUN;
                    value_next = '0;
                    tl_next    = 1'b0;
                    mask_next  = '1;
                    if (tail_start_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = '0;
                        wr_data    = CH_AMP;
                        count_next = CNT_W'(1);
                        mode_next  = MODE_NAME;
                    end
                    else
                    begin
                        count_next = '0;
                        mode_next  = MODE_PLAIN;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            count_reg      <= '0;
            mode_reg       <= MODE_PLAIN;
            value_reg      <= '0;
            tl_reg         <= 1'b0;
            mask_reg       <= '1;
            idx_reg        <= '0;
            seq_last_reg   <= '0;
            flush_len_reg  <= '0;
            end_reg        <= 1'b0;
            tail_start_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            mode_reg       <= mode_next;
            value_reg      <= value_next;
            tl_reg         <= tl_next;
            mask_reg       <= mask_next;
            idx_reg        <= idx_next;
            seq_last_reg   <= seq_last_next;
            flush_len_reg  <= flush_len_next;
            end_reg        <= end_next;
            tail_start_reg <= tail_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_byte_reg <= tail_byte_next;
        if (wr_en)
        begin
            pend_reg[wr_idx] <= wr_data;
        end
    end

endmodule

>>> design/xed_queue.sv
// Short FIFO of command words between front and back end.
// Depends on xed_pkg.
module xed_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  xed_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          nonempty,
    output xed_pkg::cmd_t head
);
    import xed_pkg::*;

    cmd_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  fill_reg, fill_next;
    logic                do_push, do_pop;

    assign full     = fill_reg == Q_CNT_W'(Q_DEPTH);
    assign nonempty = fill_reg != '0;
    assign head     = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/xed_back.sv
// Back end: expands queue words into output bytes (UTF-8 for code points)
// and holds them in the output register. Depends on xed_pkg.
module xed_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  xed_pkg::cmd_t head,
    output logic          pop,
    output logic          result_valid,
    input  logic          result_stall,
    output xed_pkg::out_t result
);
    import xed_pkg::*;

    logic              valid_reg, valid_next;
    out_t              data_reg;
    logic [1:0]        k_reg, k_next;
    logic [CODE_W-1:0] v;
    logic [1:0]        nb;
    logic [7:0]        sel_byte;
    logic              last_byte;
    logic              load;

    always_comb
    begin
        if (head.is_code && (head.value >= SURR_LO) && (head.value <= SURR_HI))
        begin
            v = REPL_CHAR;
        end
        else
        begin
            v = head.value;
        end

        // nb is the byte count less one
        priority if (!head.is_code || (v < 21'h80))
        begin
            nb = 2'd0;
        end
        else if (v < 21'h800)
        begin
            nb = 2'd1;
        end
        else if (v < 21'h10000)
        begin
            nb = 2'd2;
        end
        else
        begin
            nb = 2'd3;
        end

        unique case ({nb, k_reg})
            4'b01_00: sel_byte = {3'b110, v[10:6]};
            4'b10_00: sel_byte = {4'b1110, v[15:12]};
            4'b10_01: sel_byte = {2'b10, v[11:6]};
            4'b11_00: sel_byte = {5'b11110, v[20:18]};
            4'b11_01: sel_byte = {2'b10, v[17:12]};
            4'b11_10: sel_byte = {2'b10, v[11:6]};
            4'b01_01, 4'b10_10, 4'b11_11: sel_byte = {2'b10, v[5:0]};
            default:  sel_byte = v[7:0];
        endcase
    end

    assign last_byte    = k_reg == nb;
    assign load         = !valid_reg || !result_stall;
    assign pop          = load && q_valid && last_byte;
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        k_next     = k_reg;
        if (load)
        begin
            valid_next = q_valid;
            if (q_valid)
            begin
                k_next = last_byte ? 2'd0 : k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && q_valid)
        begin
            data_reg.out_byte <= sel_byte;
            data_reg.last_out <= head.last && last_byte;
        end
    end

endmodule

>>> design/xml_entity_decoder_unit.sv
// XML entity decoder, top level: front end, command queue, back end.
// Depends on xed_pkg, xed_front, xed_queue, xed_back.
//
// Usage:
//   Input channel item_valid/item_stall/item carries one text byte per word,
//   with end_of_text on the last byte of a string. Output channel
//   result_valid/result_stall/result carries one unescaped byte per word,
//   last_out set on the final byte of the string.
//   Named entities (lt, gt, amp, quot, apos) and decimal &#N; entities are
//   decoded; N goes out as UTF-8 of one to four bytes, surrogates as U+FFFD.
//   Anything that fails to match leaves unchanged.
//   Throughput: one input byte per cycle, one output byte per cycle, while
//   nothing stalls. A code point holds the back end until all of its UTF-8
//   bytes are out. When a candidate fails, or end_of_text arrives with
//   bytes held, the front end stalls the input while it flushes the held
//   bytes, plus the current one where it follows: at most PENDING_DEPTH + 1.
//   Each result is registered in the queue, then in the output register.
//   A stall on the result side backs up the four-word queue, then the input.
//   Reset clears all scan state; nothing is held and the block starts in
//   plain text.
module xml_entity_decoder_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  xed_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output xed_pkg::out_t result
);
    import xed_pkg::*;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_nonempty;
    cmd_t q_head;

    xed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    xed_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    xed_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_nonempty),
        .head         (q_head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
